### src/mprm_pkg.sv
package mprm_pkg;

    localparam int unsigned TABLE_ENTRIES_DEFAULT = 15;
    localparam int unsigned PORT_W = 16;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MATCH_MODE    = 2'd0,
        CFG_INVERT_RESULT = 2'd1,
        CFG_ENTRIES_USED  = 2'd2
    } cfg_index_t;

    // Port selection modes; the fourth code selects nothing.
    typedef enum logic [1:0] {
        MODE_SOURCE = 2'd0,
        MODE_DEST   = 2'd1,
        MODE_EITHER = 2'd2
    } match_mode_t;

    localparam logic OPCODE_CLASSIFY = 1'b0;
    localparam logic OPCODE_WRITE    = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [PORT_W-1:0]  source_port;
        logic [PORT_W-1:0]  dest_port;
        logic               is_fragment;
        logic               header_short;
        logic [INDEX_W-1:0] entry_index;
        logic [PORT_W-1:0]  entry_port;
        logic               entry_range_flag;
    } in_word_t;

    typedef struct packed {
        logic matched;
        logic drop_packet;
    } out_word_t;

    // Settings every cell looks at.
    typedef struct packed {
        logic [1:0]         match_mode;
        logic [INDEX_W-1:0] entries_used;
    } cell_cfg_t;

    // What travels down the chain of cells with one word.
    typedef struct packed {
        logic               active;
        logic               is_write;
        logic               forced;
        logic               drop;
        logic               hit;
        logic               skip;
        logic [PORT_W-1:0]  source_port;
        logic [PORT_W-1:0]  dest_port;
        logic [INDEX_W-1:0] entry_index;
        logic [PORT_W-1:0]  entry_port;
        logic               entry_range_flag;
    } token_t;

endpackage

### src/mprm_cell.sv
module mprm_cell
    import mprm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
    parameter int unsigned CELL_INDEX    = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              stall,
    input  cell_cfg_t         cfg,
    input  token_t            token_in,
    input  logic [PORT_W-1:0] next_port,
    output logic [PORT_W-1:0] own_port,
    output token_t            token_out
);

    localparam logic IS_LAST = (CELL_INDEX == TABLE_ENTRIES - 1);

    logic [PORT_W-1:0] port_reg;
    logic              flag_reg;
    token_t            token_reg;
    token_t            token_next;
    logic              hold;
    logic              in_use;
    logic              eligible;
    logic              ranged;
    logic [PORT_W-1:0] upper;
    logic              src_in;
    logic              dst_in;
    logic              hit_here;
    logic              write_here;

    // Only a word that is waiting at the chain output holds its cell.
    assign hold = stall && token_reg.active && IS_LAST;

    assign in_use   = (CELL_INDEX < 32'(cfg.entries_used));
    assign eligible = token_in.active && !token_in.forced && !token_in.hit
                      && !token_in.skip && in_use;
    assign ranged   = flag_reg && !IS_LAST;
    assign upper    = ranged ? next_port : port_reg;
    assign src_in   = (token_in.source_port >= port_reg) && (token_in.source_port <= upper);
    assign dst_in   = (token_in.dest_port >= port_reg) && (token_in.dest_port <= upper);

    always_comb begin
        unique case (cfg.match_mode)
            MODE_SOURCE: hit_here = eligible && src_in;
            MODE_DEST:   hit_here = eligible && dst_in;
            MODE_EITHER: hit_here = eligible && (src_in || dst_in);
            default:     hit_here = 1'b0;
        endcase
    end

    assign write_here = token_in.active && token_in.is_write
                        && (32'(token_in.entry_index) == CELL_INDEX);

    always_comb begin
        token_next      = token_in;
        token_next.hit  = token_in.hit || hit_here;
        // A range start consumes the following word as its upper end.
        token_next.skip = eligible && ranged;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg.active <= 1'b0;
        end else if (!hold) begin
            token_reg <= token_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_reg <= '0;
            flag_reg <= 1'b0;
        end else if (!hold && write_here) begin
            port_reg <= token_in.entry_port;
            flag_reg <= token_in.entry_range_flag;
        end
    end

    assign own_port  = port_reg;
    assign token_out = token_reg;

endmodule

### src/multi_port_range_matcher.sv
// Channel        | Ports                                   | Word
// ---------------+-----------------------------------------+-------------
// packet/write   | s_valid, s_ready, s_data                | in_word_t
// result         | m_valid, m_ready, m_data                | out_word_t
// configuration  | cfg_valid, cfg_ready, cfg_index, cfg_data | register value
//
// The accepting edge loads the first of TABLE_ENTRIES cells, the word moves one cell
// per cycle (it waits in the last cell while the result is stalled) and then into the
// output register. Only one word is in the chain at a time and the input reopens with
// the output register load, so no new word is taken while one is in the chain.
// Reset (aresetn low at a clock edge) clears the table, configuration, busy and m_valid.
// A stalled result holds the output register; the next word may enter and waits in the
// last cell, and the input stays closed until that word moves on.
module multi_port_range_matcher
    import mprm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers. The port always takes a write at once.
    logic [1:0]         match_mode_reg;
    logic               invert_reg;
    logic [INDEX_W-1:0] entries_used_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_mode_reg   <= '0;
            invert_reg       <= 1'b0;
            entries_used_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MATCH_MODE:    match_mode_reg   <= cfg_data[1:0];
                CFG_INVERT_RESULT: invert_reg       <= cfg_data[0];
                CFG_ENTRIES_USED:  entries_used_reg <= cfg_data[INDEX_W-1:0];
                default:           ;
            endcase
        end
    end

    cell_cfg_t cell_cfg;
    assign cell_cfg.match_mode   = match_mode_reg;
    assign cell_cfg.entries_used = entries_used_reg;

    // The chain is busy from the accept of a word until its result reaches the
    // output register.
    logic      busy_reg;
    logic      busy_next;
    logic      accept;
    logic      stall;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_word_t m_data_reg;
    out_word_t m_data_next;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign stall   = m_valid_reg && !m_ready;

    // The entering token: fragments, short headers and writes are settled
    // up front and only ride along to keep the result order.
    token_t head;
    always_comb begin
        head                  = '0;
        head.active           = accept;
        head.is_write         = (s_data.opcode == OPCODE_WRITE);
        head.forced           = (s_data.opcode == OPCODE_WRITE) || s_data.is_fragment
                                || s_data.header_short;
        head.drop             = (s_data.opcode == OPCODE_CLASSIFY) && !s_data.is_fragment
                                && s_data.header_short;
        head.source_port      = s_data.source_port;
        head.dest_port        = s_data.dest_port;
        head.entry_index      = s_data.entry_index;
        head.entry_port       = s_data.entry_port;
        head.entry_range_flag = s_data.entry_range_flag;
    end

    token_t            tokens [TABLE_ENTRIES+1];
    logic [PORT_W-1:0] ports  [TABLE_ENTRIES+1];

    assign tokens[0]             = head;
    assign ports[TABLE_ENTRIES]  = '0;

    // Each cell holds one table word and reads its right neighbor's port as
    // the upper end of a range.
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        mprm_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .CELL_INDEX    (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stall     (stall),
            .cfg       (cell_cfg),
            .token_in  (tokens[i]),
            .next_port (ports[i+1]),
            .own_port  (ports[i]),
            .token_out (tokens[i+1])
        );
    end

    token_t tail;
    assign tail = tokens[TABLE_ENTRIES];

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (!stall) begin
            m_valid_next            = tail.active;
            m_data_next.matched     = !tail.forced && (tail.hit ^ invert_reg);
            m_data_next.drop_packet = tail.drop;
            if (tail.active) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
